### sv/esks_pkg.sv
// ----------------------------------------------------------------------------
// esks_pkg: shared types and constants for the escape sequence key splitter
// Word formats, controller/datapath command and status groups, byte codes
// and the small byte classifiers used while scanning a sequence.
// ----------------------------------------------------------------------------
package esks_pkg;

    // Input word opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Timeout register value after reset
    localparam logic [15:0] TIMEOUT_RESET = 16'd20000;

    // Byte codes
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_O      = 8'h4f;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_Q      = 8'h51;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_TILDE  = 8'h7e;

    // Input and output words
    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       key_end;
        logic       last;
    } t_out_word;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_EMIT_RD,
        S_EMIT_WR,
        S_FIN
    } t_state;

    // Outcome of looking at one buffered byte during a scan
    typedef enum logic [1:0] {
        V_MORE,     // sequence goes on, look at the next byte
        V_LONE,     // front byte is a key on its own
        V_KEY       // this byte closes a multi-byte key
    } t_verdict;

    // Controller to datapath
    typedef struct packed {
        logic append;
        logic tick_inc;
        logic wait_clr;
        logic idx_clr;
        logic idx_inc;
        logic rd_scan;
        logic kind_ld;
        logic len_one;
        logic len_key;
        logic rd_pop;
        logic hold_cap;
        logic hold_flush;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic     count_zero;
        logic     count_full;
        logic     idx_at_end;
        logic     timeout_hit;
        t_verdict verdict;
        logic     rem_zero;
        logic     hold_vld;
        logic     out_free;
    } t_status;

    // SS3 final byte: P Q R S
    function automatic logic is_ss3_final(input logic [7:0] c);
        logic hit;
        case (c) inside
            CH_P, CH_Q, CH_R, CH_S: hit = 1'b1;
            default:                hit = 1'b0;
        endcase
        return hit;
    endfunction

    // CSI final byte: A B C D F H P Q R S ~
    function automatic logic is_csi_final(input logic [7:0] c);
        logic hit;
        case (c) inside
            CH_A, CH_B, CH_C, CH_D, CH_F, CH_H, CH_TILDE: hit = 1'b1;
            default:                                      hit = is_ss3_final(c);
        endcase
        return hit;
    endfunction

    // CSI parameter byte: digit or semicolon
    function automatic logic is_csi_param(input logic [7:0] c);
        logic hit;
        case (c) inside
            [CH_0:CH_9], CH_SEMI: hit = 1'b1;
            default:              hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

### sv/esks_ram.sv
// ----------------------------------------------------------------------------
// esks_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data. Read data
// holds its value on cycles without a read.
// ----------------------------------------------------------------------------
module esks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/esks_dpath.sv
// ----------------------------------------------------------------------------
// esks_dpath: datapath of the key splitter
// Ring buffer of pending bytes, scan index and classifier, emit counter,
// wait tick counter with timeout compare, one-word hold stage and the
// output word register.
// ----------------------------------------------------------------------------
module esks_dpath #(
    parameter int BUF_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  esks_pkg::t_cmd      i_cmd,
    output esks_pkg::t_status   o_status,
    input  logic [7:0]          i_data_byte,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output esks_pkg::t_out_word o_out_word
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int SW = AW + 1;

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_rem;
    logic          r_kind_csi;
    logic          r_pop_end;
    logic [15:0]   r_wait;
    logic [15:0]   r_timeout;
    logic          r_hold_vld;
    logic [7:0]    r_hold_byte;
    logic          r_hold_end;
    logic          r_out_vld;
    esks_pkg::t_out_word r_out_word;

    logic [SW-1:0] w_sum_wr;
    logic [SW-1:0] w_sum_rd;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_scan_addr;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_head_inc;
    logic [7:0]    w_rdata;
    logic          w_we;
    logic [15:0]   w_wait_inc;
    logic          w_count_full;
    logic          w_out_free;
    esks_pkg::t_verdict w_verdict;

    // Ring addressing: tail for appends, head plus scan index for scans
    assign w_sum_wr    = SW'(r_head) + SW'(r_count);
    assign w_sum_rd    = SW'(r_head) + SW'(r_idx);
    assign w_waddr     = (w_sum_wr >= SW'(BUF_DEPTH)) ? AW'(w_sum_wr - SW'(BUF_DEPTH))
                                                      : AW'(w_sum_wr);
    assign w_scan_addr = (w_sum_rd >= SW'(BUF_DEPTH)) ? AW'(w_sum_rd - SW'(BUF_DEPTH))
                                                      : AW'(w_sum_rd);
    assign w_raddr     = i_cmd.rd_pop ? r_head : w_scan_addr;
    assign w_head_inc  = (r_head == AW'(BUF_DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign w_count_full = (r_count == CW'(BUF_DEPTH));
    assign w_we        = i_cmd.append && !w_count_full;

    esks_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_data_byte),
        .i_re    (i_cmd.rd_scan || i_cmd.rd_pop),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Classify the scanned byte by its place in the sequence
    always_comb begin
        if (r_idx == CW'(0)) begin
            w_verdict = (w_rdata == esks_pkg::CH_ESC) ? esks_pkg::V_MORE : esks_pkg::V_LONE;
        end else if (r_idx == CW'(1)) begin
            w_verdict = (w_rdata == esks_pkg::CH_O || w_rdata == esks_pkg::CH_LBRACK)
                        ? esks_pkg::V_MORE : esks_pkg::V_LONE;
        end else if (!r_kind_csi) begin
            w_verdict = esks_pkg::is_ss3_final(w_rdata) ? esks_pkg::V_KEY : esks_pkg::V_LONE;
        end else if (esks_pkg::is_csi_param(w_rdata)) begin
            w_verdict = esks_pkg::V_MORE;
        end else begin
            w_verdict = esks_pkg::is_csi_final(w_rdata) ? esks_pkg::V_KEY : esks_pkg::V_LONE;
        end
    end

    // Saturating tick count and timeout compare on the incremented value
    assign w_wait_inc = (r_wait == 16'hffff) ? r_wait : r_wait + 16'd1;
    assign w_out_free = !r_out_vld || i_out_ready;

    // Buffer bookkeeping, scan and emit counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_rem      <= '0;
            r_kind_csi <= 1'b0;
            r_wait     <= '0;
            r_timeout  <= esks_pkg::TIMEOUT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (w_we) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.rd_pop) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.rd_pop) begin
                r_head <= w_head_inc;
                r_rem  <= r_rem - CW'(1);
            end else if (i_cmd.len_key) begin
                r_rem <= r_idx + CW'(1);
            end else if (i_cmd.len_one) begin
                r_rem <= CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.kind_ld && r_idx == CW'(1)) begin
                r_kind_csi <= (w_rdata == esks_pkg::CH_LBRACK);
            end
            if (i_cmd.wait_clr) begin
                r_wait <= '0;
            end else if (i_cmd.tick_inc) begin
                r_wait <= w_wait_inc;
            end
        end
    end

    // Key end flag travels with each popped byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_pop) begin
            r_pop_end <= (r_rem == CW'(1));
        end
    end

    // Hold stage: a word waits here until it is known whether another follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.hold_cap) begin
                r_hold_vld <= 1'b1;
            end else if (i_cmd.hold_flush) begin
                r_hold_vld <= 1'b0;
            end
            if ((i_cmd.hold_cap && r_hold_vld) || i_cmd.hold_flush) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_cap) begin
            r_hold_byte <= w_rdata;
            r_hold_end  <= r_pop_end;
        end
        if ((i_cmd.hold_cap && r_hold_vld) || i_cmd.hold_flush) begin
            r_out_word.key_byte <= r_hold_byte;
            r_out_word.key_end  <= r_hold_end;
            r_out_word.last     <= i_cmd.hold_flush;
        end
    end

    // Status back to the controller
    assign o_status.count_zero  = (r_count == CW'(0));
    assign o_status.count_full  = w_count_full;
    assign o_status.idx_at_end  = (r_idx == r_count);
    assign o_status.timeout_hit = (w_wait_inc >= r_timeout);
    assign o_status.verdict     = w_verdict;
    assign o_status.rem_zero    = (r_rem == CW'(0));
    assign o_status.hold_vld    = r_hold_vld;
    assign o_status.out_free    = w_out_free;

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

### sv/esks_ctrl.sv
// ----------------------------------------------------------------------------
// esks_ctrl: controller of the key splitter
// Takes one input word at a time. A byte, or a tick that hits the timeout,
// starts a step that alternates scanning the front of the buffer and
// emitting whole keys until the buffer holds nothing or an incomplete
// sequence, and finally releases the last word of the step.
module esks_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_opcode,
    input  esks_pkg::t_status i_status,
    output logic              o_in_ready,
    output esks_pkg::t_cmd    o_cmd
);

    esks_pkg::t_state r_state;
    esks_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esks_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            esks_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_opcode == esks_pkg::OP_BYTE) begin
                        o_cmd.append  = 1'b1;
                        o_cmd.idx_clr = 1'b1;
                        n_state       = esks_pkg::S_SCAN_RD;
                    end else if (!i_status.count_zero) begin
                        o_cmd.tick_inc = 1'b1;
                        if (i_status.timeout_hit) begin
                            // timeout: front byte goes out alone
                            o_cmd.wait_clr = 1'b1;
                            o_cmd.len_one  = 1'b1;
                            n_state        = esks_pkg::S_EMIT_RD;
                        end
                    end
                end
            end
            esks_pkg::S_SCAN_RD: begin
                if (i_status.count_zero) begin
                    n_state = esks_pkg::S_FIN;
                end else if (i_status.idx_at_end) begin
                    // incomplete; a full buffer flushes its front byte
                    if (i_status.count_full) begin
                        o_cmd.wait_clr = 1'b1;
                        o_cmd.len_one  = 1'b1;
                        n_state        = esks_pkg::S_EMIT_RD;
                    end else begin
                        n_state = esks_pkg::S_FIN;
                    end
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = esks_pkg::S_SCAN_EV;
                end
            end
            esks_pkg::S_SCAN_EV: begin
                o_cmd.kind_ld = 1'b1;
                unique case (i_status.verdict)
                    esks_pkg::V_MORE: begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = esks_pkg::S_SCAN_RD;
                    end
                    esks_pkg::V_KEY: begin
                        o_cmd.wait_clr = 1'b1;
                        o_cmd.len_key  = 1'b1;
                        n_state        = esks_pkg::S_EMIT_RD;
                    end
                    default: begin
                        o_cmd.wait_clr = 1'b1;
                        o_cmd.len_one  = 1'b1;
                        n_state        = esks_pkg::S_EMIT_RD;
                    end
                endcase
            end
            esks_pkg::S_EMIT_RD: begin
                o_cmd.rd_pop = 1'b1;
                n_state      = esks_pkg::S_EMIT_WR;
            end
            esks_pkg::S_EMIT_WR: begin
                // stall while the previous word cannot move to the output
                if (!i_status.hold_vld || i_status.out_free) begin
                    o_cmd.hold_cap = 1'b1;
                    if (i_status.rem_zero) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = esks_pkg::S_SCAN_RD;
                    end else begin
                        n_state = esks_pkg::S_EMIT_RD;
                    end
                end
            end
            esks_pkg::S_FIN: begin
                if (!i_status.hold_vld) begin
                    n_state = esks_pkg::S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.hold_flush = 1'b1;
                    n_state          = esks_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = esks_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### sv/escape_sequence_key_splitter.sv
// ----------------------------------------------------------------------------
// escape_sequence_key_splitter: terminal byte stream to key tokens
//
//   channel  direction  handshake                 word
//   in       input      i_in_valid / o_in_ready   t_in_word  (opcode, data_byte)
//   out      output     o_out_valid / i_out_ready t_out_word (key_byte, key_end, last)
//   cfg      input      i_cfg_we                  i_cfg_data (timeout_ticks)
//
// One word at a time. A tick without timeout emits nothing; otherwise a step
// scans bytes at the front of the buffer and emits whole keys, then releases
// the last word of the step. Each byte is read through the single read port
// of the buffer, whose read data is registered. Synchronous active-low reset
// empties the buffer and loads the timeout with 20000. A stalled output holds
// the emit sequence in place.
// ----------------------------------------------------------------------------
module escape_sequence_key_splitter #(
    parameter int BUF_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  esks_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output esks_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data
);

    esks_pkg::t_cmd    w_cmd;
    esks_pkg::t_status w_status;

    // Controller
    esks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_word.opcode),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // Datapath
    esks_dpath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_data_byte (i_in_word.data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // Between steps no word is left in the hold stage
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_status.hold_vld)
        else $error("hold stage occupied while taking a new word");

    // The buffer never stays full after a step
    a_idle_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_status.count_full)
        else $error("buffer full between steps");

    // A step always ends on the closing byte of a key
    a_last_ends_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.last) |-> o_out_word.key_end)
        else $error("last word of a step does not end a key");

    // A flush at step end shows its word as the last word of the step
    a_out_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.hold_flush) |=> (o_out_valid && o_out_word.last))
        else $error("flushed word not shown as last");

endmodule
